### rtl/core/flvd_pkg.sv
// ----------------------------------------------------------------------------
// flvd_pkg
// Shared types and constants of the FLV tag deframer: tag type codes,
// kind codes, header layout and the result word.
// ----------------------------------------------------------------------------
package flvd_pkg;

    localparam int unsigned POS_W = 24;

    // Tag type bytes as found in the stream
    localparam logic [7:0] TYPE_SCRIPT = 8'h12;
    localparam logic [7:0] TYPE_AUDIO  = 8'h08;
    localparam logic [7:0] TYPE_VIDEO  = 8'h09;
    // First video body byte of a keyframe (frame type 1, codec 7)
    localparam logic [7:0] KEYFRAME_BYTE = 8'h17;

    // Kind codes on the result channel
    localparam logic [1:0] KIND_SCRIPT = 2'd0;
    localparam logic [1:0] KIND_AUDIO  = 2'd1;
    localparam logic [1:0] KIND_VIDEO  = 2'd2;
    localparam logic [1:0] KIND_OTHER  = 2'd3;

    // Byte positions inside the file header and the tag header
    localparam logic [POS_W-1:0] FILE_HDR_LAST  = POS_W'(8);
    localparam logic [POS_W-1:0] HDR_TYPE_POS   = POS_W'(4);
    localparam logic [POS_W-1:0] HDR_LEN_POS    = POS_W'(5);
    localparam logic [POS_W-1:0] HDR_TIME_POS   = POS_W'(8);
    localparam logic [POS_W-1:0] HDR_EXT_POS    = POS_W'(11);
    localparam logic [POS_W-1:0] HDR_STREAM_POS = POS_W'(12);
    localparam logic [POS_W-1:0] TAG_HDR_LAST   = POS_W'(14);

    typedef struct packed {
        logic [7:0]       body_byte;
        logic [1:0]       tag_kind;
        logic [POS_W-1:0] body_length;
        logic [23:0]      time_low;
        logic [7:0]       time_ext;
        logic [23:0]      stream_number;
        logic [31:0]      prior_size;
        logic             is_keyframe;
        logic             first_of_tag;
        logic             last_of_tag;
    } result_t;

    function automatic logic [1:0] kind_of(input logic [7:0] tag_type);
        logic [1:0] k;
        case (tag_type)
            TYPE_SCRIPT: k = KIND_SCRIPT;
            TYPE_AUDIO:  k = KIND_AUDIO;
            TYPE_VIDEO:  k = KIND_VIDEO;
            default:     k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

### rtl/core/flvd_parser.sv
// ----------------------------------------------------------------------------
// flvd_parser
// Byte-wide FLV tag parser: tracks file header, tag header and body,
// captures the header fields and forms one result per body byte.
// ----------------------------------------------------------------------------
module flvd_parser
    import flvd_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          hdr_en,
    input  logic          in_take,
    input  logic [7:0]    in_byte,
    output logic          res_valid,
    output result_t       res
);

    typedef enum logic [1:0] {
        PH_START,
        PH_FILE,
        PH_TAGHDR,
        PH_BODY
    } phase_t;

    phase_t           phase_reg, phase_next, phase_eff;
    logic [POS_W-1:0] pos_reg, pos_next, pos_eff;
    logic [31:0]      prior_reg, prior_next;
    logic [7:0]       type_reg, type_next;
    logic [POS_W-1:0] len_reg, len_next;
    logic [23:0]      time_reg, time_next;
    logic [7:0]       ext_reg, ext_next;
    logic [23:0]      stream_reg, stream_next;
    logic             key_reg, key_next;
    logic             first, last, key_now;

    always_comb begin
        phase_eff = phase_reg;
        pos_eff   = pos_reg;
        if (phase_reg == PH_START) begin
            pos_eff   = '0;
            phase_eff = hdr_en ? PH_FILE : PH_TAGHDR;
        end

        phase_next  = phase_eff;
        pos_next    = pos_eff;
        prior_next  = prior_reg;
        type_next   = type_reg;
        len_next    = len_reg;
        time_next   = time_reg;
        ext_next    = ext_reg;
        stream_next = stream_reg;
        key_next    = key_reg;
        res_valid   = 1'b0;

        first   = (pos_eff == '0);
        last    = ({1'b0, pos_eff} + (POS_W+1)'(1)) >= {1'b0, len_reg};
        key_now = first ? ((type_reg == TYPE_VIDEO) && (in_byte == KEYFRAME_BYTE))
                        : key_reg;

        case (phase_eff)
            PH_FILE: begin
                if (pos_eff == FILE_HDR_LAST) begin
                    pos_next   = '0;
                    phase_next = PH_TAGHDR;
                end else begin
                    pos_next = pos_eff + POS_W'(1);
                end
            end
            PH_TAGHDR: begin
                if (pos_eff < HDR_TYPE_POS) begin
                    prior_next = {prior_reg[23:0], in_byte};
                end else if (pos_eff == HDR_TYPE_POS) begin
                    type_next = in_byte;
                end else if (pos_eff < HDR_TIME_POS) begin
                    len_next = {len_reg[15:0], in_byte};
                end else if (pos_eff < HDR_EXT_POS) begin
                    time_next = {time_reg[15:0], in_byte};
                end else if (pos_eff == HDR_EXT_POS) begin
                    ext_next = in_byte;
                end else begin
                    stream_next = {stream_reg[15:0], in_byte};
                end
                if (pos_eff == TAG_HDR_LAST) begin
                    // Length is complete by now; empty tags skip the body
                    pos_next   = '0;
                    phase_next = (len_reg == '0) ? PH_TAGHDR : PH_BODY;
                end else begin
                    pos_next = pos_eff + POS_W'(1);
                end
            end
            PH_BODY: begin
                res_valid = 1'b1;
                key_next  = key_now;
                if (last) begin
                    pos_next   = '0;
                    phase_next = PH_TAGHDR;
                end else begin
                    pos_next = pos_eff + POS_W'(1);
                end
            end
            default: begin
                phase_next = phase_eff;
            end
        endcase

        res.body_byte     = in_byte;
        res.tag_kind      = kind_of(type_reg);
        res.body_length   = len_reg;
        res.time_low      = time_reg;
        res.time_ext      = ext_reg;
        res.stream_number = stream_reg;
        res.prior_size    = prior_reg;
        res.is_keyframe   = key_now;
        res.first_of_tag  = first;
        res.last_of_tag   = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            pos_reg   <= '0;
        end else if (in_take) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            prior_reg  <= prior_next;
            type_reg   <= type_next;
            len_reg    <= len_next;
            time_reg   <= time_next;
            ext_reg    <= ext_next;
            stream_reg <= stream_next;
            key_reg    <= key_next;
        end
    end

endmodule

### rtl/core/flv_tag_deframer.sv
// A body byte accepted at an edge is in the result register and on m_tvalid after that edge.
// Throughput: one input byte per cycle (single parse step between parser and result
//   registers), but not while m_tvalid waits on m_tready; header bytes give no word.
// Reset (aresetn low, synchronous): parser returns to its start state, the result
//   register empties and expect_file_header returns to 1.
// ----------------------------------------------------------------------------
// flv_tag_deframer
// Splits an FLV byte stream into tags and sends every body byte with the
// fields of its tag header, a kind code, a keyframe flag and first/last marks.
// ----------------------------------------------------------------------------
module flv_tag_deframer
    import flvd_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,

    // Configuration: expect_file_header
    input  logic          cfg_wr_en,
    input  logic          cfg_wr_data,

    // Input stream
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] in_byte

    // Result stream
    output logic          m_tvalid,
    input  logic          m_tready,
    // [7:0] body_byte, [31:8] body_length, [55:32] time_low, [63:56] time_ext,
    // [87:64] stream_number, [119:88] prior_size
    output logic [119:0]  m_tdata,
    // [1:0] tag_kind, [2] is_keyframe, [3] first_of_tag
    output logic [3:0]    m_tuser,
    output logic          m_tlast    // last_of_tag
);

    logic    hdr_en_reg;
    logic    m_valid_reg;
    result_t m_res_reg;
    logic    s_take;
    logic    res_valid;
    result_t res;

    // Take a new byte whenever the result register is empty or being drained
    assign s_tready = !m_valid_reg || m_tready;
    assign s_take   = s_tvalid && s_tready;

    // Hold the header choice; the parser samples it on its first byte only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_en_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            hdr_en_reg <= cfg_wr_data;
        end
    end

    flvd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hdr_en    (hdr_en_reg),
        .in_take   (s_take),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register: load on a body byte, drop valid once the word is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_take) begin
            m_valid_reg <= res_valid;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.prior_size, m_res_reg.stream_number, m_res_reg.time_ext,
                       m_res_reg.time_low, m_res_reg.body_length, m_res_reg.body_byte};
    assign m_tuser  = {m_res_reg.first_of_tag, m_res_reg.is_keyframe, m_res_reg.tag_kind};
    assign m_tlast  = m_res_reg.last_of_tag;

    // A keyframe mark only ever rides on a video tag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_res_reg.is_keyframe |-> m_res_reg.tag_kind == KIND_VIDEO)
        else $error("keyframe flag on a non-video tag");

    // The first word of a keyframe tag carries the keyframe marker byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_res_reg.is_keyframe && m_res_reg.first_of_tag
        |-> m_res_reg.body_byte == KEYFRAME_BYTE)
        else $error("keyframe flag without marker byte");

    // A tag that starts and ends on the same word has a one-byte body
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_res_reg.first_of_tag && m_res_reg.last_of_tag
        |-> m_res_reg.body_length == POS_W'(1))
        else $error("single-word tag with length other than one");

    // No word appears right after reset
    assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> !m_valid_reg)
        else $error("result valid right after reset");

endmodule

### dv/flv_tag_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flv_tag_deframer_tb
// Self-checking bench for the FLV tag deframer. Feeds a byte stream through
// the input port: a few hand-built tags first, then random well-formed tags
// with random header fields and bodies. A behavioral parser in the bench
// predicts every body word, and the result port is compared word by word,
// with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module flv_tag_deframer_tb;
    import flvd_pkg::*;

    localparam int unsigned FILE_HDR_BYTES = 9;
    localparam int unsigned TAG_HDR_BYTES  = 15;
    localparam int unsigned STALL_PCT      = 16;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned TOTAL_ITEMS    = 1850;

    // File header: signature, version, flags, header size
    localparam logic [7:0] FLV_FILE_HDR [9] = '{
        8'h46, 8'h4C, 8'h56, 8'h01, 8'h05, 8'h00, 8'h00, 8'h00, 8'h09};

    typedef enum logic [1:0] {
        PARSE_START,
        PARSE_FILE,
        PARSE_HDR,
        PARSE_BODY
    } parse_phase_t;

    typedef struct {
        logic [7:0] data;
        bit         typed;
        result_t    want;
    } dir_row_t;

    localparam result_t NO_WORD = '0;
    // Single-byte video keyframe tag, every other header field zero
    localparam result_t KEY_WORD = '{
        body_byte: KEYFRAME_BYTE, tag_kind: KIND_VIDEO, body_length: 24'd1,
        time_low: 24'd0, time_ext: 8'd0, stream_number: 24'd0, prior_size: 32'd0,
        is_keyframe: 1'b1, first_of_tag: 1'b1, last_of_tag: 1'b1};

    // Hand-built tags: a one-byte keyframe tag with its other fields zero, then a zero-length
    // audio tag with all-ones fields, which gives no word at all
    dir_row_t directed_rows [31] = '{
        '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD}, '{TYPE_VIDEO, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}, '{8'h01, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
        '{KEYFRAME_BYTE, 1'b1, KEY_WORD},
        '{8'hFF, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, NO_WORD}, '{TYPE_AUDIO, 1'b0, NO_WORD},
        '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, NO_WORD},
        '{8'hFF, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD}
    };

    logic          aclk;
    logic          aresetn;
    logic          cfg_wr_en;
    logic          cfg_wr_data;
    logic          s_tvalid;
    logic          s_tready;
    logic [7:0]    s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [119:0]  m_tdata;
    logic [3:0]    m_tuser;
    logic          m_tlast;

    // Parser shadow: configuration and header fields of the current tag
    logic          hdr_skip_cfg;
    parse_phase_t  parse_phase;
    int unsigned   parse_pos;
    logic [31:0]   prior_size_q;
    logic [7:0]    tag_type_q;
    logic [23:0]   body_len_q;
    logic [23:0]   time_low_q;
    logic [7:0]    time_ext_q;
    logic [23:0]   stream_q;
    logic          keyframe_q;

    result_t       pending_words[$];
    int unsigned   bytes_sent;
    int unsigned   mismatches;
    int unsigned   quiet_cycles;
    int unsigned   last_body_len;
    bit            no_stall;

    flv_tag_deframer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #10 aclk = ~aclk;

    // Advance the shadow parser by one accepted byte; return the word it causes
    task automatic parse_byte(input logic [7:0] b, output bit emits, output result_t w);
        bit first_b;
        bit last_b;
        emits = 1'b0;
        w = '0;
        // The header choice is read on the first byte after reset only
        if (parse_phase == PARSE_START) begin
            parse_pos = 0;
            parse_phase = hdr_skip_cfg ? PARSE_FILE : PARSE_HDR;
        end
        if (parse_phase == PARSE_FILE) begin
            // Drop file header bytes unchecked
            parse_pos++;
            if (parse_pos >= FILE_HDR_BYTES) begin
                parse_pos = 0;
                parse_phase = PARSE_HDR;
            end
        end else if (parse_phase == PARSE_HDR) begin
            if (parse_pos < 4)
                prior_size_q = {prior_size_q[23:0], b};
            else if (parse_pos == 4)
                tag_type_q = b;
            else if (parse_pos < 8)
                body_len_q = {body_len_q[15:0], b};
            else if (parse_pos < 11)
                time_low_q = {time_low_q[15:0], b};
            else if (parse_pos == 11)
                time_ext_q = b;
            else
                stream_q = {stream_q[15:0], b};
            parse_pos++;
            if (parse_pos >= TAG_HDR_BYTES) begin
                parse_pos = 0;
                // A zero-length tag goes straight on to the next header
                parse_phase = (body_len_q == 24'd0) ? PARSE_HDR : PARSE_BODY;
            end
        end else begin
            first_b = (parse_pos == 0);
            if (first_b)
                keyframe_q = (tag_type_q == TYPE_VIDEO) && (b == KEYFRAME_BYTE);
            last_b = (parse_pos + 1 >= int'(body_len_q));
            emits = 1'b1;
            w.body_byte = b;
            case (tag_type_q)
                TYPE_SCRIPT: w.tag_kind = KIND_SCRIPT;
                TYPE_AUDIO:  w.tag_kind = KIND_AUDIO;
                TYPE_VIDEO:  w.tag_kind = KIND_VIDEO;
                default:     w.tag_kind = KIND_OTHER;
            endcase
            w.body_length   = body_len_q;
            w.time_low      = time_low_q;
            w.time_ext      = time_ext_q;
            w.stream_number = stream_q;
            w.prior_size    = prior_size_q;
            w.is_keyframe   = keyframe_q;
            w.first_of_tag  = first_b;
            w.last_of_tag   = last_b;
            if (last_b) begin
                parse_pos = 0;
                parse_phase = PARSE_HDR;
            end else begin
                parse_pos = (parse_pos + 1) & 32'hFF_FFFF;
            end
        end
    endtask

    // Offer one byte, hold it until accepted, then predict its word
    task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
        bit emits;
        result_t w;
        while (!no_stall && $urandom_range(0, 99) < STALL_PCT) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        parse_byte(b, emits, w);
        if (emits)
            pending_words.push_back(typed ? want : w);
        bytes_sent++;
    endtask

    // Drain all words, let the pipe settle, then write the header choice
    task automatic drain_and_config(input logic value);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        hdr_skip_cfg = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Build and send one well-formed tag with random content
    task automatic send_random_tag();
        logic [7:0]  tag_bytes[$];
        logic [31:0] prior;
        logic [7:0]  ttype;
        int unsigned len;
        int unsigned pick;
        logic [23:0] len24;
        logic [23:0] ts;
        logic [23:0] sid;
        prior = ($urandom_range(0, 1) == 0) ? 32'(last_body_len + 11) : 32'($urandom());
        case ($urandom_range(0, 4))
            0:       ttype = TYPE_SCRIPT;
            1:       ttype = TYPE_AUDIO;
            2, 3:    ttype = TYPE_VIDEO;
            default: ttype = 8'($urandom());
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 10)
            len = 0;
        else if (pick < 85)
            len = $urandom_range(1, 8);
        else if (pick < 98)
            len = $urandom_range(9, 40);
        else
            len = $urandom_range(200, 300);
        len24 = 24'(len);
        ts    = 24'($urandom());
        sid   = 24'($urandom());
        tag_bytes = '{prior[31:24], prior[23:16], prior[15:8], prior[7:0], ttype,
                      len24[23:16], len24[15:8], len24[7:0],
                      ts[23:16], ts[15:8], ts[7:0], 8'($urandom()),
                      sid[23:16], sid[15:8], sid[7:0]};
        for (int i = 0; i < len; i++) begin
            // Lead video bodies with the keyframe marker at random, one time in two
            if (i == 0 && ttype == TYPE_VIDEO && $urandom_range(0, 1) == 1)
                tag_bytes.push_back(KEYFRAME_BYTE);
            else
                tag_bytes.push_back(8'($urandom()));
        end
        foreach (tag_bytes[k])
            send_byte(tag_bytes[k], 1'b0, NO_WORD);
        last_body_len = len;
    endtask

    // Receiver: stall at random unless a quiet stretch is running
    always @(negedge aclk) begin
        m_tready <= no_stall || ($urandom_range(0, 99) >= STALL_PCT);
    end

    // Compare every accepted result word with the oldest prediction
    always @(posedge aclk) begin : result_check
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{body_byte: m_tdata[7:0], tag_kind: m_tuser[1:0],
                    body_length: m_tdata[31:8], time_low: m_tdata[55:32],
                    time_ext: m_tdata[63:56], stream_number: m_tdata[87:64],
                    prior_size: m_tdata[119:88], is_keyframe: m_tuser[2],
                    first_of_tag: m_tuser[3], last_of_tag: m_tlast};
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word, actual %h", $time, got);
                mismatches++;
            end else begin
                want = pending_words.pop_front();
                if (got.body_byte !== want.body_byte ||
                    got.tag_kind !== want.tag_kind ||
                    got.body_length !== want.body_length ||
                    got.time_low !== want.time_low ||
                    got.time_ext !== want.time_ext ||
                    got.stream_number !== want.stream_number ||
                    got.prior_size !== want.prior_size ||
                    got.is_keyframe !== want.is_keyframe ||
                    got.first_of_tag !== want.first_of_tag ||
                    got.last_of_tag !== want.last_of_tag) begin
                    $display("%0t: word mismatch, expected %p, actual %p", $time, want, got);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run when no word moves on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = 8'h00;
        m_tready      = 1'b0;
        hdr_skip_cfg  = 1'b1;
        parse_phase   = PARSE_START;
        parse_pos     = 0;
        prior_size_q  = '0;
        tag_type_q    = '0;
        body_len_q    = '0;
        time_low_q    = '0;
        time_ext_q    = '0;
        stream_q      = '0;
        keyframe_q    = 1'b0;
        bytes_sent    = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        last_body_len = 0;
        no_stall      = 1'b0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The seed picks the header choice; it sticks until the next reset
        drain_and_config(1'($urandom_range(0, 1)));

        // Skip a file header first when it is expected
        if (hdr_skip_cfg) begin
            foreach (FLV_FILE_HDR[i])
                send_byte(FLV_FILE_HDR[i], 1'b0, NO_WORD);
        end
        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);

        // Later writes must not change the parse
        drain_and_config(1'b0);

        while (bytes_sent < 600)
            send_random_tag();
        // Run a stretch without any stalls on either side
        no_stall = 1'b1;
        while (bytes_sent < 900)
            send_random_tag();
        no_stall = 1'b0;

        // Hold the sender until every word is out, then flip the setting back
        drain_and_config(1'b1);

        while (bytes_sent < TOTAL_ITEMS)
            send_random_tag();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);

        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
